>>> rtl/tpla_pkg.sv
// ----------------------------------------------------------------------------
// tpla_pkg
// Shared types and constants for the toolpath length accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package tpla_pkg;

  // Fixed widths of the result fields and the move kind
  localparam int unsigned STEP_W      = 25;
  localparam int unsigned TOTAL_OUT_W = 48;
  localparam int unsigned KIND_W      = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_RAPID   = 2'd0,
    KIND_FEED    = 2'd1,
    KIND_OTHER_A = 2'd2,
    KIND_OTHER_B = 2'd3
  } move_kind_e;

  // Status of the square-root unit
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

`default_nettype wire

>>> rtl/tpla_sqrt.sv
// ----------------------------------------------------------------------------
// tpla_sqrt
// Restoring integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tpla_sqrt import tpla_pkg::*; #(
  parameter int unsigned ROOT_W = 25
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [2*ROOT_W-1:0]   radicand_i,
  output logic      [ROOT_W-1:0]     root_o,
  output sqrt_stat_t                 stat_o
);

  localparam int unsigned RAD_W = 2 * ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned CNT_W = $clog2(ROOT_W);

  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [REM_W-1:0]  cand;
  logic [REM_W-1:0]  trial;
  logic [REM_W-1:0]  rem_sub;
  logic              take;

  // Bring down the next two radicand bits and try the next root bit
  always_comb begin
    cand    = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
    trial   = {root_q, 2'b01};
    take    = (cand >= trial);
    rem_sub = cand - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(ROOT_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= take ? rem_sub : cand;
      root_q <= {root_q[ROOT_W-2:0], take};
    end
  end

  assign root_o      = root_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

>>> rtl/toolpath_length_accumulator.sv
// ----------------------------------------------------------------------------
// toolpath_length_accumulator
// Flow: square and sum the three axis differences, take the root, commit the
//   result once the output register is free; a path-start or first move after
//   reset skips squares and root. No new request is taken until idle again;
//   most of the time goes to the bit-serial square root, one root bit per cycle.
// Reset: asynchronous, active low; totals and last target cleared, idle.
// ----------------------------------------------------------------------------
`default_nettype none

module toolpath_length_accumulator import tpla_pkg::*; #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned TOTAL_BITS = 48
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Request channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         path_start_i,
  input  wire logic [KIND_W-1:0]            move_kind_i,
  input  wire logic signed [COORD_BITS-1:0] target_x_i,
  input  wire logic signed [COORD_BITS-1:0] target_y_i,
  input  wire logic signed [COORD_BITS-1:0] target_z_i,
  // Result channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [STEP_W-1:0]                 step_length_o,
  output logic [TOTAL_OUT_W-1:0]            feed_length_o,
  output logic [TOTAL_OUT_W-1:0]            rapid_length_o
);

  // Root of three summed squares of COORD_BITS-bit magnitudes needs one
  // more bit than a coordinate; the radicand is twice that.
  localparam int unsigned ROOT_W = COORD_BITS + 1;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned PROD_W = 2 * COORD_BITS;
  localparam int unsigned SUM_W  =
    ((TOTAL_BITS > ROOT_W) ? TOTAL_BITS : ROOT_W) + 1;
  localparam logic [TOTAL_BITS-1:0] TOT_MAX = {TOTAL_BITS{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_FINISH
  } state_e;

  // Control state
  state_e                 state_q, state_d;
  logic [1:0]             cnt_q, cnt_d;
  logic                   have_prev_q, have_prev_d;
  logic [COORD_BITS-1:0]  last_q [3];
  logic [COORD_BITS-1:0]  last_d [3];
  logic [TOTAL_BITS-1:0]  feed_q, feed_d;
  logic [TOTAL_BITS-1:0]  rapid_q, rapid_d;
  logic                   out_valid_q, out_valid_d;

  // Payload
  logic                   start_q, start_d;
  move_kind_e             kind_q, kind_d;
  logic [COORD_BITS-1:0]  diff_q [3];
  logic [COORD_BITS-1:0]  diff_d [3];
  logic [PROD_W-1:0]      prod_q, prod_d;
  logic [RAD_W-1:0]       acc_q, acc_d;
  logic [ROOT_W-1:0]      step_q, step_d;
  logic [STEP_W-1:0]      out_step_q, out_step_d;
  logic [TOTAL_OUT_W-1:0] out_feed_q, out_feed_d;
  logic [TOTAL_OUT_W-1:0] out_rapid_q, out_rapid_d;

  // Working signals
  logic [COORD_BITS-1:0]  tgt [3];
  logic [COORD_BITS:0]    dfull;
  logic [COORD_BITS-1:0]  sq_op;
  logic [TOTAL_BITS-1:0]  tot_sel;
  logic [SUM_W-1:0]       sum_full;
  logic [TOTAL_BITS-1:0]  tot_sat;
  logic                   out_free;
  logic                   sq_start;
  logic [ROOT_W-1:0]      sq_root;
  sqrt_stat_t             sq_stat;

  // Bit-serial square-root unit
  tpla_sqrt #(
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (acc_q),
    .root_o     (sq_root),
    .stat_o     (sq_stat)
  );

  // Absolute axis differences against the stored target; the signed
  // difference fits one extra bit, its magnitude fits COORD_BITS.
  always_comb begin
    tgt[0] = target_x_i;
    tgt[1] = target_y_i;
    tgt[2] = target_z_i;
    dfull  = '0;
    for (int a = 0; a < 3; a++) begin
      dfull     = {tgt[a][COORD_BITS-1], tgt[a]} -
                  {last_q[a][COORD_BITS-1], last_q[a]};
      diff_d[a] = dfull[COORD_BITS] ? COORD_BITS'(-dfull) : dfull[COORD_BITS-1:0];
    end
  end

  // One multiplier, stepped over the three axes
  always_comb begin
    case (cnt_q)
      2'd0:    sq_op = diff_q[0];
      2'd1:    sq_op = diff_q[1];
      default: sq_op = diff_q[2];
    endcase
    prod_d = sq_op * sq_op;
  end

  // Saturating add of the step into the total chosen by the move kind
  always_comb begin
    tot_sel  = (kind_q == KIND_FEED) ? feed_q : rapid_q;
    sum_full = SUM_W'(tot_sel) + SUM_W'(step_q);
    tot_sat  = (sum_full > SUM_W'(TOT_MAX)) ? TOT_MAX : sum_full[TOTAL_BITS-1:0];
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    have_prev_d = have_prev_q;
    last_d      = last_q;
    feed_d      = feed_q;
    rapid_d     = rapid_q;
    start_d     = start_q;
    kind_d      = kind_q;
    acc_d       = acc_q;
    step_d      = step_q;
    out_step_d  = out_step_q;
    out_feed_d  = out_feed_q;
    out_rapid_d = out_rapid_q;
    sq_start    = 1'b0;

    // Drop the result once the far side takes it
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          start_d     = path_start_i;
          kind_d      = move_kind_e'(move_kind_i);
          last_d      = tgt;
          have_prev_d = 1'b1;
          cnt_d       = '0;
          acc_d       = '0;
          step_d      = '0;
          // No previous target in this path: record it, measure nothing
          if (path_start_i || !have_prev_q) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SQUARE;
          end
        end
      end
      ST_SQUARE: begin
        // Product of the previous axis lands while the next one multiplies
        if (cnt_q != 2'd0) begin
          acc_d = acc_q + RAD_W'(prod_q);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 2'd3) begin
          state_d = ST_ROOT_GO;
        end
      end
      ST_ROOT_GO: begin
        sq_start = 1'b1;
        state_d  = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (sq_stat.done) begin
          step_d  = sq_root;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold until the output register is free, then commit once
        if (out_free) begin
          if (start_q) begin
            feed_d  = '0;
            rapid_d = '0;
          end else if (kind_q == KIND_FEED) begin
            feed_d = tot_sat;
          end else if (kind_q == KIND_RAPID) begin
            rapid_d = tot_sat;
          end
          out_step_d  = STEP_W'(step_q);
          out_feed_d  = TOTAL_OUT_W'(feed_d);
          out_rapid_d = TOTAL_OUT_W'(rapid_d);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      have_prev_q <= 1'b0;
      last_q      <= '{default: '0};
      feed_q      <= '0;
      rapid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      have_prev_q <= have_prev_d;
      last_q      <= last_d;
      feed_q      <= feed_d;
      rapid_q     <= rapid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q     <= start_d;
    kind_q      <= kind_d;
    prod_q      <= prod_d;
    acc_q       <= acc_d;
    step_q      <= step_d;
    out_step_q  <= out_step_d;
    out_feed_q  <= out_feed_d;
    out_rapid_q <= out_rapid_d;
    if (state_q == ST_IDLE) begin
      diff_q <= diff_d;
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign step_length_o  = out_step_q;
  assign feed_length_o  = out_feed_q;
  assign rapid_length_o = out_rapid_q;

endmodule

`default_nettype wire

>>> rtl/tpla_checker.sv
// ----------------------------------------------------------------------------
// tpla_checker
// Port-level checks for the toolpath length accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module tpla_checker import tpla_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_stall_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire logic [STEP_W-1:0]      step_length_o,
  input wire logic [TOTAL_OUT_W-1:0] feed_length_o,
  input wire logic [TOTAL_OUT_W-1:0] rapid_length_o
);

  // A taken request makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block not busy after accepting a request");

  // Returning to idle always leaves a result on offer
  a_idle_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("block went idle without a result");

  // A new result appears only as the block goes idle
  a_result_at_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result raised while block still busy");

  // Hold a stalled result
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(step_length_o) &&
      $stable(feed_length_o) && $stable(rapid_length_o))
    else $error("stalled result changed or dropped");

endmodule

bind toolpath_length_accumulator tpla_checker u_tpla_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .step_length_o  (step_length_o),
  .feed_length_o  (feed_length_o),
  .rapid_length_o (rapid_length_o)
);

`default_nettype wire
